// File: design/dlr_pkg.sv
// Shared types and constants for the digit-to-limb repacker.
`default_nettype none

package dlr_pkg;

  localparam int DIGIT_BITS = 30;
  localparam int LIMB_BITS  = 64;
  localparam int MAX_DIGITS = 4096;
  localparam int CNT_W      = 13;
  localparam int IDX_W      = 11;
  localparam int POS_W      = 8;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_IDLE,
    KIND_ABSORB,
    KIND_STRADDLE,
    KIND_DROP
  } dlr_kind_e;

  typedef struct packed {
    logic [DIGIT_BITS-1:0] digit_value;
    logic                  first_digit;
    logic [CNT_W-1:0]      digit_count;
    logic [IDX_W-1:0]      limb_count;
  } dlr_in_t;

  typedef struct packed {
    logic [LIMB_BITS-1:0] limb_value;
    logic [IDX_W-1:0]     limb_index;
    logic                 last_limb;
  } dlr_out_t;

  // One classified digit, handed from the front end to the back end.
  typedef struct packed {
    logic [DIGIT_BITS-1:0]   digit;
    logic                    clear;
    dlr_kind_e               kind;
    logic signed [POS_W-1:0] bit_pos;
    logic [IDX_W-1:0]        limb_index;
    logic                    last;
  } dlr_op_t;

endpackage

`default_nettype wire

// File: design/dlr_front.sv
// Front end: tracks bit position, limb index and digit countdown, and classifies each digit.
`default_nettype none

module dlr_front import dlr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  input  wire dlr_in_t in_data_i,
  output logic         in_ready_o,
  output logic         op_valid_o,
  output dlr_op_t      op_o,
  input  wire logic    op_ready_i
);

  localparam int SW = 20;

  logic signed [POS_W-1:0] bit_pos_q, bit_pos_d;
  logic [IDX_W-1:0]        limb_idx_q, limb_idx_d;
  logic [CNT_W-1:0]        digits_q, digits_d;

  logic [CNT_W-1:0]        dc_sat;
  logic [IDX_W-1:0]        idx_first;
  logic [SW-1:0]           start_wide;
  logic signed [SW-1:0]    start_s;
  logic signed [POS_W-1:0] start_pos;
  logic signed [POS_W-1:0] pos_eff;
  logic [IDX_W-1:0]        idx_eff;
  logic [CNT_W-1:0]        cnt_eff;
  logic                    active;
  logic                    accept;
  dlr_kind_e               kind;

  assign in_ready_o = op_ready_i;
  assign accept     = in_valid_i && op_ready_i;
  assign op_valid_o = accept;

  always_comb begin
    dc_sat = (in_data_i.digit_count > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
                                                          : in_data_i.digit_count;
    idx_first = (in_data_i.limb_count == '0) ? '0 : in_data_i.limb_count - 1'b1;
    // Wraps in SW bits; the true value always fits, so the signed view is exact.
    start_wide = SW'(dc_sat) * SW'(DIGIT_BITS) - SW'(idx_first) * SW'(LIMB_BITS)
               - SW'(DIGIT_BITS);
    start_s = $signed(start_wide);
    if (start_s > 20'sd127) begin
      start_pos = 8'sd127;
    end else if (start_s < -20'sd128) begin
      start_pos = -8'sd128;
    end else begin
      start_pos = start_s[POS_W-1:0];
    end

    pos_eff = in_data_i.first_digit ? start_pos : bit_pos_q;
    idx_eff = in_data_i.first_digit ? idx_first : limb_idx_q;
    cnt_eff = in_data_i.first_digit ? dc_sat : digits_q;
    active  = (cnt_eff != '0);

    if (!active) begin
      kind = KIND_IDLE;
    end else if (!pos_eff[POS_W-1]) begin
      kind = KIND_ABSORB;
    end else if (idx_eff != '0) begin
      kind = KIND_STRADDLE;
    end else begin
      kind = KIND_DROP;
    end

    bit_pos_d  = pos_eff;
    limb_idx_d = idx_eff;
    digits_d   = active ? cnt_eff - 1'b1 : cnt_eff;
    case (kind)
      KIND_ABSORB: begin
        bit_pos_d = pos_eff - POS_W'(DIGIT_BITS);
      end
      KIND_STRADDLE: begin
        bit_pos_d  = pos_eff + POS_W'(LIMB_BITS - DIGIT_BITS);
        limb_idx_d = idx_eff - 1'b1;
      end
      default: begin
      end
    endcase

    op_o.digit      = in_data_i.digit_value;
    op_o.clear      = in_data_i.first_digit;
    op_o.kind       = kind;
    op_o.bit_pos    = pos_eff;
    op_o.limb_index = idx_eff;
    op_o.last       = active && (cnt_eff == CNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_pos_q  <= '0;
      limb_idx_q <= '0;
      digits_q   <= '0;
    end else if (accept) begin
      bit_pos_q  <= bit_pos_d;
      limb_idx_q <= limb_idx_d;
      digits_q   <= digits_d;
    end
  end

endmodule

`default_nettype wire

// File: design/dlr_fifo.sv
// Short queue of classified digits between the front end and the back end.
`default_nettype none

module dlr_fifo import dlr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire dlr_op_t data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output dlr_op_t      data_o
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  dlr_op_t             mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntW'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: design/dlr_back.sv
// Back end: shifts digits into the limb accumulator and registers completed limbs.
`default_nettype none

module dlr_back import dlr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    op_valid_i,
  input  wire dlr_op_t op_i,
  output logic         op_pop_o,
  output logic         out_valid_o,
  output dlr_out_t     out_data_o,
  input  wire logic    out_ready_i
);

  logic [LIMB_BITS-1:0] acc_q, acc_d;
  logic                 out_valid_q, out_valid_d;
  dlr_out_t             out_q, out_d;

  logic [LIMB_BITS-1:0] acc_base;
  logic [LIMB_BITS-1:0] digit_w;
  logic [LIMB_BITS-1:0] shl_cur;
  logic [LIMB_BITS-1:0] shr_cur;
  logic [LIMB_BITS-1:0] shl_next;
  logic signed [POS_W:0] pos_x;
  logic signed [POS_W:0] rsh;
  logic signed [POS_W:0] next_pos;
  logic                 emit;
  dlr_out_t             res;
  logic                 pop;

  assign pop         = op_valid_i && (!out_valid_q || out_ready_i);
  assign op_pop_o    = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    acc_base = op_i.clear ? '0 : acc_q;
    digit_w  = LIMB_BITS'(op_i.digit);
    pos_x    = {op_i.bit_pos[POS_W-1], op_i.bit_pos};
    rsh      = -pos_x;
    next_pos = pos_x + (POS_W+1)'(LIMB_BITS);

    // Shifts of 64 or more, and left shifts by a negative amount, give zero.
    shl_cur  = op_i.bit_pos[POS_W-2] ? '0 : (digit_w << op_i.bit_pos[5:0]);
    shr_cur  = (rsh[POS_W:6] != '0) ? '0 : (digit_w >> rsh[5:0]);
    shl_next = next_pos[POS_W] ? '0 : (digit_w << next_pos[5:0]);

    acc_d = acc_base;
    emit  = 1'b0;
    res   = '{limb_value: '0, limb_index: '0, last_limb: 1'b0};
    case (op_i.kind)
      KIND_ABSORB: begin
        acc_d = acc_base | shl_cur;
      end
      KIND_STRADDLE: begin
        acc_d = shl_next;
        emit  = 1'b1;
        res   = '{limb_value: acc_base | shr_cur, limb_index: op_i.limb_index,
                  last_limb: 1'b0};
      end
      default: begin
        acc_d = acc_base;
      end
    endcase

    // The final digit always reports limb 0, replacing a straddle result.
    if (op_i.last) begin
      emit = 1'b1;
      res  = '{limb_value: acc_d, limb_index: '0, last_limb: 1'b1};
    end

    if (pop) begin
      out_valid_d = emit;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
    out_d = (pop && emit) ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        acc_q <= acc_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// File: design/digit_to_limb_repack.sv
// Top level of the 30-bit digit to 64-bit limb repacker.
`default_nettype none

// Takes a big integer as 30-bit digits, most significant first, and returns it as
// 64-bit limbs, most significant first; the request that carries first_digit also
// carries the digit and limb counts, which must be exact. One digit request is taken
// every clock cycle while the queue has room: the front end updates bit position,
// limb index and countdown with one add per digit, and the back end does one shift
// and OR into the accumulator per digit. A completed limb goes through the queue and
// then the output register, and the final digit returns limb 0 with last_limb set.
// A two-entry queue sits between front and back, so input keeps flowing for up to two
// requests while the output is stalled; in steady back-to-back flow one entry is
// already occupied, so only one more request gets in before the input backs up.
module digit_to_limb_repack import dlr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dlr_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output dlr_out_t      out_data_o
);

  logic    op_push;
  logic    op_full;
  logic    op_empty;
  logic    op_pop;
  dlr_op_t op_in;
  dlr_op_t op_out;

  dlr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .op_valid_o (op_push),
    .op_o       (op_in),
    .op_ready_i (!op_full)
  );

  dlr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .data_i  (op_in),
    .full_o  (op_full),
    .pop_i   (op_pop),
    .empty_o (op_empty),
    .data_o  (op_out)
  );

  dlr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!op_empty),
    .op_i        (op_out),
    .op_pop_o    (op_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_ready_i (out_ready_i)
  );

  // The input only backs up when the output was stalled in the cycle before.
  a_ready_low_only_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i)
  ) else $error("input stalled without an output stall");

  // Only limb 0 carries the last flag, and straddle results never go to limb 0.
  a_last_matches_index: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_limb == (out_data_o.limb_index == '0))
  ) else $error("last_limb disagrees with limb_index");

  // A result that is taken is gone unless the back end popped a new one.
  a_no_repeat: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && op_empty) |=> !out_valid_o
  ) else $error("result repeated without a new digit");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the digit-to-limb repacker, with a built-in limb predictor.
`timescale 1ns / 100ps

module testbench;
  import dlr_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  typedef struct {
    bit      hold;
    dlr_in_t req;
  } digit_slot_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  dlr_in_t  in_data = '0;
  logic     out_ready = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  dlr_out_t out_data_o;

  digit_slot_t digits_pending[$];
  dlr_out_t    limbs_due[$];
  int          mismatch_count = 0;

  digit_to_limb_repack uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always #10 clk = ~clk;

  // Predictor state for the number currently being repacked.
  logic [LIMB_BITS-1:0] acc_bits = '0;
  int                   pos_bits = 0;
  int unsigned          limb_idx = 0;
  int unsigned          digits_left = 0;

  function automatic int clamp_pos(longint v);
    if (v > 127) return 127;
    if (v < -128) return -128;
    return int'(v);
  endfunction

  function automatic logic [LIMB_BITS-1:0] shift_up(logic [LIMB_BITS-1:0] x, longint n);
    if (n < 0 || n >= 64) return '0;
    return x << n;
  endfunction

  function automatic logic [LIMB_BITS-1:0] shift_down(logic [LIMB_BITS-1:0] x, longint n);
    if (n < 0) return x;
    if (n >= 64) return '0;
    return x >> n;
  endfunction

  function automatic bit repack_digit(input dlr_in_t req, output dlr_out_t limb);
    logic [LIMB_BITS-1:0] d;
    int unsigned          cnt;
    longint               bp;
    bit                   emitted;
    d = LIMB_BITS'(req.digit_value);
    emitted = 1'b0;
    limb = '0;
    if (req.first_digit) begin
      cnt = 32'(req.digit_count);
      if (cnt > MAX_DIGITS) cnt = MAX_DIGITS;
      limb_idx = (req.limb_count == '0) ? 0 : 32'(req.limb_count) - 1;
      digits_left = cnt;
      acc_bits = '0;
      pos_bits = clamp_pos(longint'(cnt) * DIGIT_BITS - longint'(limb_idx) * LIMB_BITS
                           - DIGIT_BITS);
    end
    if (digits_left == 0) return 1'b0;
    if (pos_bits >= 0) begin
      acc_bits = acc_bits | shift_up(d, longint'(pos_bits));
      pos_bits = clamp_pos(longint'(pos_bits) - DIGIT_BITS);
    end else if (limb_idx != 0) begin
      // The digit straddles a limb boundary: its top completes this limb.
      bp = longint'(pos_bits);
      limb.limb_value = acc_bits | shift_down(d, -bp);
      limb.limb_index = IDX_W'(limb_idx);
      limb.last_limb = 1'b0;
      emitted = 1'b1;
      bp = bp + LIMB_BITS;
      acc_bits = shift_up(d, bp);
      limb_idx = limb_idx - 1;
      pos_bits = clamp_pos(bp - DIGIT_BITS);
    end
    digits_left = digits_left - 1;
    if (digits_left == 0) begin
      limb.limb_value = acc_bits;
      limb.limb_index = '0;
      limb.last_limb = 1'b1;
      emitted = 1'b1;
    end
    return emitted;
  endfunction

  function automatic logic [DIGIT_BITS-1:0] pick_digit(fill_e fill);
    case (fill)
      FILL_ONES:  return '1;
      FILL_ZEROS: return '0;
      default: begin
        if ($urandom_range(0, 15) == 0) return '1;
        if ($urandom_range(0, 15) == 0) return '0;
        return DIGIT_BITS'($urandom);
      end
    endcase
  endfunction

  task automatic queue_digit(logic [DIGIT_BITS-1:0] value, logic first,
                             logic [CNT_W-1:0] dcount, logic [IDX_W-1:0] lcount);
    digit_slot_t slot;
    slot.hold = 1'b0;
    slot.req.digit_value = value;
    slot.req.first_digit = first;
    slot.req.digit_count = dcount;
    slot.req.limb_count = lcount;
    digits_pending.push_back(slot);
  endtask

  task automatic queue_pause();
    digit_slot_t slot;
    slot.hold = 1'b1;
    slot.req = '0;
    digits_pending.push_back(slot);
  endtask

  // A well-formed number with exact digit and limb counts; the count fields of
  // the later digits carry junk, since the block reads them only on the first.
  task automatic queue_number(int n, fill_e fill);
    int lcount;
    lcount = (n * DIGIT_BITS + LIMB_BITS - 1) / LIMB_BITS;
    queue_digit(pick_digit(fill), 1'b1, CNT_W'(n), IDX_W'(lcount));
    for (int k = 1; k < n; k++)
      queue_digit(pick_digit(fill), 1'b0, CNT_W'($urandom), IDX_W'($urandom));
  endtask

  // Driver: bursts of requests separated by random gaps, plus drain pauses.
  always @(posedge clk or negedge rst_n) begin : drive
    digit_slot_t next;
    int          burst_left;
    int          gap_left;
    bit          draining;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      draining = 1'b0;
    end else if (!in_valid || in_ready_o) begin
      if (draining) begin
        if (limbs_due.size() == 0) draining = 1'b0;
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (digits_pending.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        next = digits_pending.pop_front();
        if (next.hold) begin
          draining = 1'b1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= next.req;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(10, 30);
            else gap_left = $urandom_range(1, 4);
          end
        end
      end
    end
  end

  // Receiver: stretches without stalls alternate with stretches of short
  // and occasional long stalls.
  always @(posedge clk or negedge rst_n) begin : receive
    int stall_left;
    int cyc;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      cyc = 0;
    end else begin
      cyc++;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (cyc[9] && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: checks each accepted limb, then predicts from each accepted digit.
  always @(posedge clk) begin : observe
    dlr_out_t want;
    dlr_out_t got;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        if (limbs_due.size() == 0) begin
          $display("%0t: limb expected none actual value %h index %0d last %0b", $time,
                   out_data_o.limb_value, out_data_o.limb_index, out_data_o.last_limb);
          mismatch_count++;
        end else begin
          want = limbs_due.pop_front();
          if (out_data_o.limb_value !== want.limb_value) begin
            $display("%0t: limb_value expected %h actual %h", $time,
                     want.limb_value, out_data_o.limb_value);
            mismatch_count++;
          end
          if (out_data_o.limb_index !== want.limb_index) begin
            $display("%0t: limb_index expected %0d actual %0d", $time,
                     want.limb_index, out_data_o.limb_index);
            mismatch_count++;
          end
          if (out_data_o.last_limb !== want.last_limb) begin
            $display("%0t: last_limb expected %0b actual %0b", $time,
                     want.last_limb, out_data_o.last_limb);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready_o) begin
        if (repack_digit(in_data, got)) limbs_due.push_back(got);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int    work_items;
    int    pick;
    int    roll;
    int    len;
    fill_e fill;

    // Directed part.
    queue_digit('1, 1'b0, '1, '1);             // no number active: ignored
    queue_number(1, FILL_ONES);
    queue_number(3, FILL_ONES);                // top digit straddles
    queue_number(2, FILL_ZEROS);
    queue_digit(pick_digit(FILL_RANDOM), 1'b1, '0, IDX_W'(5));  // empty number
    queue_digit('1, 1'b1, '1, '1);             // count saturates, position clamps low
    queue_digit('1, 1'b0, '0, '0);
    queue_digit(pick_digit(FILL_RANDOM), 1'b0, '0, '0);
    queue_digit('1, 1'b1, CNT_W'(MAX_DIGITS), IDX_W'(1920));
    queue_digit('1, 1'b0, '0, '0);
    queue_digit('0, 1'b0, '1, '1);
    queue_digit('1, 1'b1, CNT_W'(3), '0);      // zero limb count
    queue_digit('1, 1'b0, '0, '0);
    queue_digit('1, 1'b0, '0, '0);
    queue_digit('1, 1'b1, CNT_W'(6), IDX_W'(1));  // position clamps high, then drops
    repeat (5) queue_digit('1, 1'b0, '0, '0);
    queue_digit('1, 1'b1, CNT_W'(1), IDX_W'(2));  // straddle on the last digit
    queue_pause();

    // Random part: mostly well-formed numbers, some broken ones and noise.
    work_items = 0;
    while (work_items < 950) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) len = $urandom_range(1, 8);
        else if (roll < 97) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 150);
        roll = $urandom_range(0, 19);
        fill = (roll == 0) ? FILL_ONES : (roll == 1) ? FILL_ZEROS : FILL_RANDOM;
        queue_number(len, fill);
        work_items += len;
      end else if (pick < 85) begin
        len = $urandom_range(0, 6);
        queue_digit(pick_digit(FILL_RANDOM), 1'b1, CNT_W'($urandom), IDX_W'($urandom));
        repeat (len)
          queue_digit(pick_digit(FILL_RANDOM), 1'b0, CNT_W'($urandom), IDX_W'($urandom));
        work_items += len + 1;
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 3))
          queue_digit(pick_digit(FILL_RANDOM), 1'b0, CNT_W'($urandom), IDX_W'($urandom));
      end else begin
        queue_pause();
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (digits_pending.size() != 0 || in_valid) @(negedge clk);
    while (limbs_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && limbs_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
